### src/hbm_pkg.sv
// Package for the Hebbian associative memory core.
// Holds fixed payload widths, request and register codes, and pipeline control types.
// No dependencies.
`timescale 1ns / 1ps

package hbm_pkg;

	localparam int IN_BITS_W  = 16;
	localparam int OUT_BITS_W = 16;

	localparam int LEN_W = 5;
	localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Register index, taken from the word address bit of paddr.
	localparam logic REG_PATTERN_LENGTH = 1'b0;

	localparam logic REQ_STORE  = 1'b0;
	localparam logic REQ_RECALL = 1'b1;

	// Control that travels with a weight row read.
	typedef struct packed {
		logic vld;
		logic store;
		logic last;
	} row_ctl_t;

	// Control that travels with a recall decision.
	typedef struct packed {
		logic vld;
		logic last;
	} dec_ctl_t;

endpackage

### src/hbm_intf.sv
// Valid/ready channel interfaces for the request and response beats.
// Depends on hbm_pkg for the payload widths.
`timescale 1ns / 1ps

interface hbm_req_if;
	logic                           valid;
	logic                           ready;
	logic                           req_type;
	logic [hbm_pkg::IN_BITS_W-1:0]  pattern_bits;

	modport source (output valid, output req_type, output pattern_bits, input ready);
	modport sink   (input valid, input req_type, input pattern_bits, output ready);
endinterface

interface hbm_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [hbm_pkg::OUT_BITS_W-1:0] recalled_bits;

	modport source (output valid, output recalled_bits, input ready);
	modport sink   (input valid, input recalled_bits, output ready);
endinterface

### src/hbm_apb_regs.sv
// APB configuration register block: holds the pattern length register.
// Depends on hbm_pkg for widths, reset value and register index.
`timescale 1ns / 1ps

module hbm_apb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hbm_pkg::PADDR_W-1:0]  paddr,
	input  logic [hbm_pkg::PDATA_W-1:0]  pwdata,
	output logic [hbm_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output logic [hbm_pkg::LEN_W-1:0]    pattern_length
);

	logic [hbm_pkg::LEN_W-1:0] len_q;
	logic                      wr_hit;

	assign pready = 1'b1;
	assign wr_hit = psel && penable && pwrite &&
		(paddr[hbm_pkg::PADDR_W-1] == hbm_pkg::REG_PATTERN_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= hbm_pkg::LEN_RESET;
		end else if (wr_hit) begin
			len_q <= pwdata[hbm_pkg::LEN_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[hbm_pkg::PADDR_W-1] == hbm_pkg::REG_PATTERN_LENGTH) begin
			prdata = {{(hbm_pkg::PDATA_W - hbm_pkg::LEN_W){1'b0}}, len_q};
		end
	end

	assign pattern_length = len_q;

endmodule

### src/hbm_weight_mem.sv
// Weight matrix storage, one matrix row per memory word, registered read data.
// A row valid bit per row makes an unwritten row read as all zero weights after reset.
`timescale 1ns / 1ps

module hbm_weight_mem #(
	parameter int ROWS   = 16,
	parameter int WORD_W = 144
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [$clog2(ROWS)-1:0]   rd_row,
	output logic [WORD_W-1:0]         rd_data,
	input  logic                      wr_en,
	input  logic [$clog2(ROWS)-1:0]   wr_row,
	input  logic [WORD_W-1:0]         wr_data
);

	logic [WORD_W-1:0] mem_q [ROWS];
	logic [ROWS-1:0]   row_vld_q;
	logic [WORD_W-1:0] rd_word_q;
	logic              rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_row] <= wr_data;
		end
		if (rd_en) begin
			rd_word_q <= mem_q[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				row_vld_q[wr_row] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= row_vld_q[rd_row];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_word_q : '0;

endmodule

### src/hbm_row_unit.sv
// Shared row unit: one weight row per cycle across all lanes.
// Store: saturating +/-1 update per lane. Recall: registered group sums, then sign decision.
`timescale 1ns / 1ps

module hbm_row_unit #(
	parameter int MAX_LENGTH   = 16,
	parameter int WEIGHT_LIMIT = 255,
	parameter int WW           = 9,
	parameter int RW           = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hbm_pkg::row_ctl_t             ctl,
	input  logic [RW-1:0]                 row,
	input  logic [MAX_LENGTH-1:0]         pat,
	input  logic [MAX_LENGTH-1:0]         mask,
	input  logic [MAX_LENGTH*WW-1:0]      rd_data,
	output logic                          wr_en,
	output logic [RW-1:0]                 wr_row,
	output logic [MAX_LENGTH*WW-1:0]      wr_data,
	output hbm_pkg::dec_ctl_t             dec,
	output logic [RW-1:0]                 dec_row,
	output logic                          dec_bit
);

	localparam int SW = WW + $clog2(MAX_LENGTH) + 1;
	localparam int NG = (MAX_LENGTH + 7) / 8;
	localparam logic signed [WW-1:0] W_MAX = WW'(WEIGHT_LIMIT);
	localparam logic signed [WW-1:0] W_MIN = -W_MAX;

	logic signed [WW-1:0] w      [MAX_LENGTH];
	logic signed [WW-1:0] w_new  [MAX_LENGTH];
	logic signed [SW-1:0] term   [MAX_LENGTH];
	logic signed [SW-1:0] gsum   [NG];
	logic signed [SW-1:0] gsum_s2 [NG];
	logic signed [SW-1:0] total;
	logic                 pj;
	logic                 pj_s2;
	logic [RW-1:0]        row_s2;
	hbm_pkg::dec_ctl_t    dec_s2;

	assign pj = pat[row];

	always_comb begin
		for (int k = 0; k < MAX_LENGTH; k++) begin
			w[k]     = rd_data[k*WW +: WW];
			w_new[k] = w[k];
			if (mask[k]) begin
				if (pat[k] == pj) begin
					if (w[k] != W_MAX) begin
						w_new[k] = w[k] + WW'(1);
					end
				end else begin
					if (w[k] != W_MIN) begin
						w_new[k] = w[k] - WW'(1);
					end
				end
			end
			wr_data[k*WW +: WW] = w_new[k];
			term[k] = '0;
			if (mask[k]) begin
				term[k] = pat[k] ? SW'(w[k]) : -SW'(w[k]);
			end
		end
	end

	// Lanes are summed in groups of eight before the register.
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			gsum[g] = '0;
			for (int i = 0; i < 8; i++) begin
				if (g * 8 + i < MAX_LENGTH) begin
					gsum[g] = gsum[g] + term[g * 8 + i];
				end
			end
		end
	end

	assign wr_en  = ctl.vld && ctl.store;
	assign wr_row = row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_s2 <= '0;
		end else begin
			dec_s2.vld  <= ctl.vld && !ctl.store;
			dec_s2.last <= ctl.last;
		end
	end

	always_ff @(posedge clk) begin
		row_s2  <= row;
		pj_s2   <= pj;
		gsum_s2 <= gsum;
	end

	always_comb begin
		total = '0;
		for (int g = 0; g < NG; g++) begin
			total = total + gsum_s2[g];
		end
	end

	// A zero sum keeps the input element.
	assign dec_bit = (total > 0) ? 1'b1 : ((total < 0) ? 1'b0 : pj_s2);
	assign dec     = dec_s2;
	assign dec_row = row_s2;

endmodule

### src/hebbian_associative_memory_core.sv
// Hebbian associative memory core: bipolar Hopfield-style store and recall.
// With n = min(pattern_length, MAX_LENGTH): a store is done once row n - 1 is written, and
// a recall result beat appears once all n row decisions are loaded into the output register.
// Requests are taken only while idle, so they do not overlap. The single weight memory read
// port feeds the shared row unit one row per cycle; a stalled result beat holds the core.
// Reset (arst_n, asynchronous) clears all weights through row valid bits and sets length 16.
`timescale 1ns / 1ps

module hebbian_associative_memory_core #(
	parameter int MAX_LENGTH   = 16,
	parameter int WEIGHT_LIMIT = 255
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hbm_pkg::PADDR_W-1:0]   paddr,
	input  logic [hbm_pkg::PDATA_W-1:0]   pwdata,
	output logic [hbm_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	hbm_req_if.sink                       req,
	hbm_rsp_if.source                     rsp
);

	// Weight width holds +/-WEIGHT_LIMIT; row index and element count widths follow MAX_LENGTH.
	localparam int WW = $clog2(WEIGHT_LIMIT + 1) + 1;
	localparam int RW = $clog2(MAX_LENGTH);
	localparam int NW = $clog2(MAX_LENGTH + 1);
	localparam int CW = (NW > hbm_pkg::LEN_W) ? NW : hbm_pkg::LEN_W;
	localparam int IW = (MAX_LENGTH > hbm_pkg::IN_BITS_W) ? MAX_LENGTH : hbm_pkg::IN_BITS_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT,
		ST_FIN
	} state_t;

	state_t                         state_q;
	logic [hbm_pkg::LEN_W-1:0]      pattern_length;
	logic [CW-1:0]                  len_ext;
	logic [NW-1:0]                  n_in;
	logic [IW-1:0]                  pat_ext;
	logic [IW-1:0]                  vec_ext;
	logic [MAX_LENGTH-1:0]          mask_in;

	logic [NW-1:0]                  n_q;
	logic [RW-1:0]                  idx_q;
	logic [MAX_LENGTH-1:0]          pat_q;
	logic [MAX_LENGTH-1:0]          mask_q;
	logic                           store_q;
	logic [MAX_LENGTH-1:0]          vec_q;
	logic                           out_vld_q;
	logic [hbm_pkg::OUT_BITS_W-1:0] out_bits_q;
	logic                           last_row;
	logic                           out_load;

	hbm_pkg::row_ctl_t              ctl_s1;
	logic [RW-1:0]                  row_s1;

	logic [MAX_LENGTH*WW-1:0]       rd_data;
	logic                           wr_en;
	logic [RW-1:0]                  wr_row;
	logic [MAX_LENGTH*WW-1:0]       wr_data;
	hbm_pkg::dec_ctl_t              dec;
	logic [RW-1:0]                  dec_row;
	logic                           dec_bit;

	hbm_apb_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.pattern_length (pattern_length)
	);

	hbm_weight_mem #(
		.ROWS   (MAX_LENGTH),
		.WORD_W (MAX_LENGTH * WW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (state_q == ST_RUN),
		.rd_row  (idx_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_row  (wr_row),
		.wr_data (wr_data)
	);

	hbm_row_unit #(
		.MAX_LENGTH   (MAX_LENGTH),
		.WEIGHT_LIMIT (WEIGHT_LIMIT),
		.WW           (WW),
		.RW           (RW)
	) u_row (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_s1),
		.row     (row_s1),
		.pat     (pat_q),
		.mask    (mask_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_row  (wr_row),
		.wr_data (wr_data),
		.dec     (dec),
		.dec_row (dec_row),
		.dec_bit (dec_bit)
	);

	// The active length saturates at MAX_LENGTH.
	assign len_ext = CW'(pattern_length);
	assign n_in    = (len_ext > CW'(MAX_LENGTH)) ? NW'(MAX_LENGTH) : NW'(len_ext);

	// Elements at index 16 or more have no input bit and read as -1, that is 0.
	assign pat_ext = IW'(req.pattern_bits);

	always_comb begin
		for (int k = 0; k < MAX_LENGTH; k++) begin
			mask_in[k] = NW'(k) < n_in;
		end
	end

	// Output bits at index 16 or more are dropped; inactive rows stay zero.
	assign vec_ext = IW'(vec_q);

	assign last_row = (NW'(idx_q) + NW'(1)) == n_q;

	// The output register takes a new result when it is empty or its beat leaves this cycle.
	assign out_load = (state_q == ST_FIN) && (!out_vld_q || rsp.ready);

	assign req.ready         = (state_q == ST_IDLE);
	assign rsp.valid         = out_vld_q;
	assign rsp.recalled_bits = out_bits_q;

	// Sequencer: walks rows 0..n-1 through the memory read port, then waits for the
	// row unit pipeline to drain. A recall result lands in the output register, which
	// is loaded only once the previous result beat has been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			out_vld_q  <= 1'b0;
			out_bits_q <= '0;
			ctl_s1     <= '0;
			row_s1     <= '0;
			pat_q      <= '0;
			mask_q     <= '0;
			n_q        <= '0;
			store_q    <= 1'b0;
			vec_q      <= '0;
			idx_q      <= '0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			if (state_q == ST_RUN) begin
				ctl_s1.vld   <= 1'b1;
				ctl_s1.store <= store_q;
				ctl_s1.last  <= last_row;
			end else begin
				ctl_s1 <= '0;
			end
			if (dec.vld) begin
				vec_q[dec_row] <= dec_bit;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						pat_q   <= pat_ext[MAX_LENGTH-1:0];
						mask_q  <= mask_in;
						n_q     <= n_in;
						store_q <= (req.req_type == hbm_pkg::REQ_STORE);
						vec_q   <= '0;
						idx_q   <= '0;
						// With no active element a store changes nothing and a recall
						// returns all zeros.
						if (n_in == '0) begin
							state_q <= (req.req_type == hbm_pkg::REQ_STORE) ? ST_IDLE : ST_FIN;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					row_s1 <= idx_q;
					idx_q  <= idx_q + RW'(1);
					if (last_row) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (store_q && ctl_s1.vld && ctl_s1.last) begin
						state_q <= ST_IDLE;
					end else if (dec.vld && dec.last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						out_bits_q <= vec_ext[hbm_pkg::OUT_BITS_W-1:0];
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> (!ctl_s1.vld && !dec.vld))
		else $error("row pipeline busy while taking a new request");

	a_write_only_store: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> store_q)
		else $error("weight write during a recall");

	a_dec_only_recall: assert property (@(posedge clk) disable iff (!arst_n)
		dec.vld |-> !store_q)
		else $error("recall decision during a store");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == ST_FIN))
		else $error("result beat raised outside the finish step");

endmodule

### tb/sv/hbm_recall_checker.sv
// Checker for the Hebbian associative memory core: follows register writes and request beats,
// keeps its own weight matrix, and compares every response beat with the predicted recall.
// Depends on hbm_pkg and the channel interfaces in hbm_intf.
`timescale 1ns / 1ps

module hbm_recall_checker #(
	parameter int MAX_LENGTH   = 16,
	parameter int WEIGHT_LIMIT = 255
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hbm_pkg::PADDR_W-1:0]   paddr,
	input  logic [hbm_pkg::PDATA_W-1:0]   pwdata,
	input  logic [hbm_pkg::PDATA_W-1:0]   prdata,
	input  logic                          pready,
	hbm_req_if                            req,
	hbm_rsp_if                            rsp,
	output int                            mismatches,
	output int                            pending
);

	localparam int WEIGHT_W = $clog2(WEIGHT_LIMIT + 1) + 1;

	logic [hbm_pkg::LEN_W-1:0]       length_q;
	logic signed [WEIGHT_W-1:0]      weight_q [MAX_LENGTH][MAX_LENGTH];
	logic [hbm_pkg::OUT_BITS_W-1:0]  recall_q [$];
	logic [hbm_pkg::OUT_BITS_W-1:0]  want;

	function automatic int active_len();
		return (int'(length_q) > MAX_LENGTH) ? MAX_LENGTH : int'(length_q);
	endfunction

	// Element i as +1 or -1; elements past the input width read as -1.
	function automatic int bipolar(input logic [hbm_pkg::IN_BITS_W-1:0] bits, input int i);
		if (i >= hbm_pkg::IN_BITS_W)
			return -1;
		return bits[i] ? 1 : -1;
	endfunction

	function automatic void learn_pattern(input logic [hbm_pkg::IN_BITS_W-1:0] bits);
		int n;
		int w;
		n = active_len();
		for (int j = 0; j < n; j++) begin
			for (int k = 0; k < n; k++) begin
				w = int'(weight_q[j][k]) + bipolar(bits, j) * bipolar(bits, k);
				if (w > WEIGHT_LIMIT)
					w = WEIGHT_LIMIT;
				if (w < -WEIGHT_LIMIT)
					w = -WEIGHT_LIMIT;
				weight_q[j][k] = WEIGHT_W'(w);
			end
		end
	endfunction

	function automatic logic [hbm_pkg::OUT_BITS_W-1:0] recall_pattern(
			input logic [hbm_pkg::IN_BITS_W-1:0] bits);
		int n;
		int sum;
		logic one;
		logic [hbm_pkg::OUT_BITS_W-1:0] outv;
		n = active_len();
		outv = '0;
		for (int j = 0; j < n; j++) begin
			sum = 0;
			for (int k = 0; k < n; k++)
				sum += int'(weight_q[j][k]) * bipolar(bits, k);
			if (sum > 0)
				one = 1'b1;
			else if (sum < 0)
				one = 1'b0;
			else
				one = (bipolar(bits, j) > 0);
			if (one && j < hbm_pkg::OUT_BITS_W)
				outv[j] = 1'b1;
		end
		return outv;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q = hbm_pkg::LEN_RESET;
			for (int j = 0; j < MAX_LENGTH; j++)
				for (int k = 0; k < MAX_LENGTH; k++)
					weight_q[j][k] = '0;
			recall_q.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (psel && penable && pready &&
					((paddr >> 2) == hbm_pkg::REG_PATTERN_LENGTH)) begin
				if (pwrite) begin
					length_q = pwdata[hbm_pkg::LEN_W-1:0];
				end else if (prdata !==
						{{(hbm_pkg::PDATA_W-hbm_pkg::LEN_W){1'b0}}, length_q}) begin
					$display("%0t: pattern_length read mismatch, expected %h, actual %h",
						$time, {{(hbm_pkg::PDATA_W-hbm_pkg::LEN_W){1'b0}}, length_q},
						prdata);
					mismatches++;
				end
			end
			// A response beat always belongs to an earlier request, so it is checked first.
			if (rsp.valid && rsp.ready) begin
				if (recall_q.size() == 0) begin
					$display("%0t: recalled_bits beat with nothing pending, expected none, actual %h",
						$time, rsp.recalled_bits);
					mismatches++;
				end else begin
					want = recall_q.pop_front();
					if (rsp.recalled_bits !== want) begin
						$display("%0t: recalled_bits mismatch, expected %h, actual %h",
							$time, want, rsp.recalled_bits);
						mismatches++;
					end
				end
			end
			if (req.valid && req.ready) begin
				if (req.req_type == hbm_pkg::REQ_STORE)
					learn_pattern(req.pattern_bits);
				else
					recall_q.push_back(recall_pattern(req.pattern_bits));
			end
			pending = recall_q.size();
		end
	end

endmodule

### tb/sv/hebbian_associative_memory_core_tb.sv
// Testbench top for the Hebbian associative memory core: clock, reset, register and request
// stimulus with random idling on both channels, and the final verdict.
// Depends on hbm_pkg, hbm_intf, the core itself and hbm_recall_checker.
`timescale 1ns / 1ps

module hebbian_associative_memory_core_tb;

	localparam int MAX_LEN    = 16;
	localparam int WEIGHT_LIM = 255;
	// A store gives no beat and may still be walking its rows when the last recall beat has
	// arrived, so after the queue runs dry we allow the longest store latency plus margin.
	localparam int SETTLE_CYCLES = MAX_LEN + 8;
	localparam int POOL_MAX      = 4;

	localparam logic [hbm_pkg::PADDR_W-1:0] LEN_ADDR   = {hbm_pkg::REG_PATTERN_LENGTH, 2'b00};
	// The word right after the only register; writes there must be ignored.
	localparam logic [hbm_pkg::PADDR_W-1:0] SPARE_ADDR = {~hbm_pkg::REG_PATTERN_LENGTH, 2'b00};

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [hbm_pkg::PADDR_W-1:0] paddr;
	logic [hbm_pkg::PDATA_W-1:0] pwdata;
	logic [hbm_pkg::PDATA_W-1:0] prdata;
	logic                        pready;

	int send_gap_pct;
	int stall_pct;
	int mismatches;
	int pending;

	logic [hbm_pkg::IN_BITS_W-1:0] mem_pat [POOL_MAX];

	hbm_req_if req_ch ();
	hbm_rsp_if rsp_ch ();

	hebbian_associative_memory_core #(
		.MAX_LENGTH   (MAX_LEN),
		.WEIGHT_LIMIT (WEIGHT_LIM)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	hbm_recall_checker #(
		.MAX_LENGTH   (MAX_LEN),
		.WEIGHT_LIMIT (WEIGHT_LIM)
	) chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// The response side stalls at random; the rate is changed per phase by the stimulus.
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Hard stop in case the core hangs. The slowest legal run is well under a tenth of this.
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// One APB transfer: setup cycle, then access cycle until pready is seen at a rising edge.
	task automatic apb_access(input logic wr, input logic [hbm_pkg::PADDR_W-1:0] addr,
			input logic [hbm_pkg::PDATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Offer one request beat, after a random number of idle cycles, and hold it until taken.
	// Valid is only written once per falling edge, so back-to-back beats keep it high.
	task automatic send_beat(input logic kind, input logic [hbm_pkg::IN_BITS_W-1:0] bits);
		while ($urandom_range(99) < send_gap_pct) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid        <= 1'b1;
		req_ch.req_type     <= kind;
		req_ch.pattern_bits <= bits;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Bring the core to rest: no beat offered, no recall outstanding, last store finished.
	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// The length register is only touched while the core is idle; it is read back each time.
	task automatic set_length(input int len);
		drain();
		apb_access(1'b1, LEN_ADDR, hbm_pkg::PDATA_W'(len));
		apb_access(1'b0, LEN_ADDR, '0);
	endtask

	// A random run at one length. Stores mostly come from a small pool of memories so that
	// weights build up and saturate; recalls are mostly corrupted copies of those memories,
	// which is where the attractor behavior shows. The rest is plain noise.
	task automatic run_segment(input int len, input int count, input int pool_n,
			input int store_pct);
		logic [hbm_pkg::IN_BITS_W-1:0] base;
		logic [hbm_pkg::IN_BITS_W-1:0] bits;
		logic [hbm_pkg::IN_BITS_W-1:0] flips;
		int pick;
		set_length(len);
		for (int i = 0; i < pool_n; i++)
			mem_pat[i] = hbm_pkg::IN_BITS_W'($urandom);
		repeat (count) begin
			base = mem_pat[$urandom_range(pool_n - 1)];
			pick = $urandom_range(99);
			if ($urandom_range(99) < store_pct) begin
				// The complement has the same outer product, so it reinforces the memory too.
				if (pick < 75)
					bits = base;
				else if (pick < 87)
					bits = ~base;
				else
					bits = hbm_pkg::IN_BITS_W'($urandom);
				send_beat(hbm_pkg::REQ_STORE, bits);
			end else begin
				flips = '0;
				repeat ($urandom_range(3, 1))
					flips[$urandom_range(hbm_pkg::IN_BITS_W - 1)] = 1'b1;
				if (pick < 15)
					bits = hbm_pkg::IN_BITS_W'($urandom);
				else if (pick < 30)
					bits = base;
				else
					bits = base ^ flips;
				send_beat(hbm_pkg::REQ_RECALL, bits);
			end
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		req_ch.valid        = 1'b0;
		req_ch.req_type     = hbm_pkg::REQ_STORE;
		req_ch.pattern_bits = '0;
		rsp_ch.ready        = 1'b0;
		send_gap_pct        = 0;
		stall_pct           = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset length of 16. With all weights zero every sum ties,
		// so a recall must hand back its own input.
		send_beat(hbm_pkg::REQ_RECALL, 16'h0000);
		send_beat(hbm_pkg::REQ_RECALL, 16'hFFFF);
		send_beat(hbm_pkg::REQ_RECALL, 16'hA5C3);
		// All-ones and all-zeros give the same outer product: every weight becomes positive.
		send_beat(hbm_pkg::REQ_STORE, 16'hFFFF);
		send_beat(hbm_pkg::REQ_RECALL, 16'h0000);
		// Eight ones against eight zeros sums to zero on every row, so the input is kept.
		send_beat(hbm_pkg::REQ_RECALL, 16'h00FF);
		send_beat(hbm_pkg::REQ_STORE, 16'h0000);
		send_beat(hbm_pkg::REQ_STORE, 16'h00FF);
		send_beat(hbm_pkg::REQ_RECALL, 16'h00FE);
		send_beat(hbm_pkg::REQ_RECALL, 16'h7F00);
		send_beat(hbm_pkg::REQ_STORE, 16'h8001);
		send_beat(hbm_pkg::REQ_RECALL, 16'h8000);
		send_beat(hbm_pkg::REQ_RECALL, 16'h0001);

		// Length zero: stores change nothing and recalls come back all zero.
		set_length(0);
		send_beat(hbm_pkg::REQ_STORE, 16'h1234);
		send_beat(hbm_pkg::REQ_RECALL, 16'hFFFF);
		// A single active element.
		set_length(1);
		send_beat(hbm_pkg::REQ_STORE, 16'h0001);
		send_beat(hbm_pkg::REQ_RECALL, 16'h0000);
		send_beat(hbm_pkg::REQ_RECALL, 16'hFFFF);
		// The largest value the register holds must act as the full width.
		set_length(31);
		send_beat(hbm_pkg::REQ_STORE, 16'h5555);
		send_beat(hbm_pkg::REQ_RECALL, 16'h5554);
		// A write past the register list must leave the length alone; the read shows it.
		drain();
		apb_access(1'b1, SPARE_ADDR, 32'hFFFF_FFFF);
		apb_access(1'b0, LEN_ADDR, '0);

		// Phase one: light sender gaps, heavy response stalls.
		send_gap_pct = 11;
		stall_pct    = 45;
		run_segment(16, 150, 3, 55);
		run_segment(1, 50, 2, 50);
		run_segment(0, 40, 2, 50);
		run_segment(31, 120, 2, 60);
		// Hundreds of stores of one memory drive the small corner into saturation both ways.
		run_segment(4, 300, 1, 88);

		// Phase two: the other way round.
		send_gap_pct = 45;
		stall_pct    = 11;
		run_segment(2, 60, 2, 50);
		run_segment(17, 120, 3, 55);
		run_segment(9, 120, 4, 45);

		// Phase three: no idling on either side, full-width saturation, then fresh memories
		// that have to pull the weights back off the limit.
		send_gap_pct = 0;
		stall_pct    = 0;
		run_segment(16, 320, 1, 90);
		run_segment(12, 100, 3, 50);
		run_segment(16, 140, 4, 40);

		drain();
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### files.f
src/hbm_pkg.sv
src/hbm_intf.sv
src/hbm_apb_regs.sv
src/hbm_weight_mem.sv
src/hbm_row_unit.sv
src/hebbian_associative_memory_core.sv
tb/sv/hbm_recall_checker.sv
tb/sv/hebbian_associative_memory_core_tb.sv
